[src/hfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfe_pkg
// Widths, constants and coefficient tables for the Hermite function evaluator.
// ----------------------------------------------------------------------------
package hfe_pkg;

   localparam int MAX_ORDER     = 31;
   localparam int OUT_FRAC_BITS = 30;

   localparam int ORDER_W    = 5;
   localparam int POS_W      = 24;
   localparam int AMP_W      = OUT_FRAC_BITS + 1;
   localparam int REQ_DATA_W = ((ORDER_W + POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((AMP_W + 7) / 8) * 8;

   localparam int K_W           = $clog2(MAX_ORDER + 1);
   localparam int EXP_FRAC_BITS = 30;
   localparam int J_W           = $clog2(EXP_FRAC_BITS + 1);

   localparam int COEF_W  = 31;   // A_k in Q1.30, B_k and exp roots fit as well
   localparam int C_W     = 31;   // A_k * x in Q.25
   localparam int MANT_W  = 34;   // normalized mantissa, |p| < 2^33
   localparam int ACC_W   = 40;   // fresh recurrence value before renormalizing
   localparam int EXP_W   = 11;   // shared block exponent
   localparam int T_W     = 32;   // x^2/2 in Q8.24
   localparam int M_W     = 32;   // 2^-f in Q1.31
   localparam int SAT_W   = (OUT_FRAC_BITS + 1 > MANT_W) ? OUT_FRAC_BITS + 1 : MANT_W;

   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = 64;

   localparam int MANT_POINT   = 31;   // mantissa value is p * 2^-(31 + E)
   localparam int LSHIFT_LIMIT = 30;

   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [30:0] PI_M4_Q31 = 31'd1613029824;

   typedef logic [MAX_ORDER:0][COEF_W-1:0]     coef_tab_type;
   typedef logic [EXP_FRAC_BITS:0][COEF_W-1:0] root_tab_type;

   // square root rounded to nearest, elaboration only
   function automatic logic [63:0] isqrt_rnd(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bits;
      logic [63:0] rem;
      res  = '0;
      bits = 64'd1 << 62;
      rem  = v;
      while (bits > rem) bits = bits >> 2;
      while (bits != 64'd0) begin
         if (rem >= res + bits) begin
            rem = rem - (res + bits);
            res = (res >> 1) + bits;
         end else begin
            res = res >> 1;
         end
         bits = bits >> 2;
      end
      if (rem > res) res = res + 64'd1;
      return res;
   endfunction

   // restoring shift-subtract quotient, elaboration only
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r    = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic coef_tab_type build_coef_a();
      coef_tab_type tab;
      tab = '0;
      for (int k = 1; k <= MAX_ORDER; k++) begin
         tab[k] = COEF_W'(isqrt_rnd(udiv(64'd1 << 61, 64'(k))));
      end
      return tab;
   endfunction

   function automatic coef_tab_type build_coef_b();
      coef_tab_type tab;
      tab = '0;
      for (int k = 1; k <= MAX_ORDER; k++) begin
         tab[k] = COEF_W'(isqrt_rnd((64'd1 << 60) -
                                    udiv((64'd1 << 60) + 64'(k - 1), 64'(k))));
      end
      return tab;
   endfunction

   // r_j ~ 2^(-2^-j) in Q0.31
   function automatic root_tab_type build_roots();
      root_tab_type tab;
      logic [63:0]  r;
      r      = 64'd1 << 30;
      tab    = '0;
      tab[0] = COEF_W'(r);
      for (int j = 1; j <= EXP_FRAC_BITS; j++) begin
         r      = isqrt_rnd(r << 31);
         tab[j] = COEF_W'(r);
      end
      return tab;
   endfunction

   localparam coef_tab_type COEF_A   = build_coef_a();
   localparam coef_tab_type COEF_B   = build_coef_b();
   localparam root_tab_type EXP_ROOT = build_roots();

   // symmetric rounding shift: sign(v) * ((|v| + 2^(s-1)) >> s)
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned s);
      logic [63:0] mag;
      logic [63:0] r;
      mag = v[63] ? (~v + 64'd1) : v;
      r   = (mag + (64'd1 << (s - 1))) >> s;
      return v[63] ? -$signed(r) : $signed(r);
   endfunction

endpackage

[src/hermite_function_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_function_evaluator
// Normalized harmonic-oscillator eigenfunction psi_n(x) by the normalized
// recurrence, in block floating point on one shared multiplier.
// ----------------------------------------------------------------------------
// Sequence: once the word is taken, x^2*log2(e)/2 is formed, 2^-f is built from
//   a root for each set bit of its 30-bit fraction and scaled by pi^-1/4, then
//   the recurrence runs up to order n with single-bit renormalizing shifts.
// One word at a time; the shared 34x33 multiplier sets the pace. req_tready
//   returns when the result moves into the output register.
// Reset (synchronous): sequencer to idle, output register empty.
// ----------------------------------------------------------------------------
module hermite_function_evaluator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [hfe_pkg::REQ_DATA_W-1:0] req_tdata,  // order[4:0], position[28:5]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hfe_pkg::RSP_DATA_W-1:0] rsp_tdata   // amplitude[30:0]
);
   import hfe_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_SQ, S_T, S_U, S_EF, S_EXP, S_EXPW, S_P0, S_P0W,
      S_CA, S_C, S_M1, S_M1W, S_SUB, S_NORM, S_OUT1, S_OUT2
   } state_type;

   localparam logic signed [11:0] OUT_SHIFT_BIAS = 12'(MANT_POINT - OUT_FRAC_BITS);
   localparam logic [ACC_W-1:0]   MANT_LIMIT     = ACC_W'(1) << (MANT_W - 1);

   state_type                   state_ff, state_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic [AMP_W-1:0]            amp_ff, amp_in;

   logic [K_W-1:0]              n_ff, n_in;
   logic [K_W-1:0]              k_ff, k_in;
   logic signed [POS_W-1:0]     x_ff, x_in;
   logic [T_W-1:0]              t_ff, t_in;
   logic signed [EXP_W-1:0]     e_ff, e_in;
   logic [EXP_FRAC_BITS-1:0]    f_ff, f_in;
   logic [J_W-1:0]              j_ff, j_in;
   logic [M_W-1:0]              m_ff, m_in;
   logic signed [C_W-1:0]       c_ff, c_in;
   logic signed [MANT_W-1:0]    bterm_ff, bterm_in;
   logic signed [ACC_W-1:0]     aterm_ff, aterm_in;
   logic signed [ACC_W-1:0]     cur_ff, cur_in;
   logic signed [MANT_W-1:0]    prev_ff, prev_in;
   logic [SAT_W-1:0]            mag_ff, mag_in;
   logic                        neg_ff, neg_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;

   logic signed [MUL_A_W-1:0]         mul_a;
   logic signed [MUL_B_W-1:0]         mul_b;
   logic signed [MUL_A_W+MUL_B_W-1:0] prod_full;

   logic [ORDER_W-1:0]          req_order;
   logic signed [POS_W-1:0]     req_position;
   logic [47:0]                 tsum;
   logic [PROD_W-1:0]           msum;
   logic signed [PROD_W-1:0]    rs24, rs25, rs30, cur_half, prev_half;
   logic [ACC_W-1:0]            cur_abs;
   logic                        mant_big;
   logic                        exp_last;
   logic signed [11:0]          s_val, s_neg;
   logic [5:0]                  rsh;
   logic [4:0]                  lsh;
   logic [63:0]                 shifted;
   logic [SAT_W-1:0]            lim_now, lim_out, mag_sat, amp_full;

   assign req_order    = req_tdata[ORDER_W-1:0];
   assign req_position = $signed(req_tdata[ORDER_W+POS_W-1:ORDER_W]);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'(amp_ff);

   // shared multiplier, operands picked by the sequencer
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ: begin
            mul_a = MUL_A_W'(x_ff);
            mul_b = MUL_B_W'(x_ff);
         end
         S_U: begin
            mul_a = MUL_A_W'(t_ff);
            mul_b = MUL_B_W'(LOG2E_Q30);
         end
         S_EXP: begin
            mul_a = MUL_A_W'(m_ff);
            mul_b = MUL_B_W'(EXP_ROOT[j_ff]);
         end
         S_P0: begin
            mul_a = MUL_A_W'(m_ff);
            mul_b = MUL_B_W'(PI_M4_Q31);
         end
         S_CA: begin
            mul_a = MUL_A_W'(COEF_A[k_ff]);
            mul_b = MUL_B_W'(x_ff);
         end
         S_C: begin
            mul_a = prev_ff;
            mul_b = MUL_B_W'(COEF_B[k_ff]);
         end
         S_M1: begin
            mul_a = cur_ff[MANT_W-1:0];
            mul_b = MUL_B_W'(c_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_full = mul_a * mul_b;
   assign prod_in   = prod_full[PROD_W-1:0];

   assign tsum      = prod_ff[47:0] + 48'd16384;
   assign msum      = prod_ff + (PROD_W'(1) << 30);
   assign rs24      = round_shift(prod_ff, 24);
   assign rs25      = round_shift(prod_ff, 25);
   assign rs30      = round_shift(prod_ff, 30);
   assign cur_half  = round_shift(PROD_W'(cur_ff), 1);
   assign prev_half = round_shift(PROD_W'(prev_ff), 1);
   assign cur_abs   = cur_ff[ACC_W-1] ? ACC_W'(-cur_ff) : ACC_W'(cur_ff);
   assign mant_big  = (cur_abs >= MANT_LIMIT);
   assign exp_last  = (j_ff == J_W'(EXP_FRAC_BITS));

   // output scaling from the shared exponent
   always_comb begin
      s_val   = $signed({e_ff[EXP_W-1], e_ff}) + OUT_SHIFT_BIAS;
      s_neg   = -s_val;
      rsh     = s_val[5:0];
      lsh     = s_neg[4:0];
      lim_now = cur_ff[ACC_W-1] ? (SAT_W'(1) << OUT_FRAC_BITS)
                                : (SAT_W'(1) << OUT_FRAC_BITS) - SAT_W'(1);
      shifted = 64'(cur_abs[MANT_W-1:0]);
      if (s_val > 12'sd0) begin
         if (s_val > $signed(12'(MANT_W))) begin
            shifted = '0;
         end else begin
            shifted = (64'(cur_abs[MANT_W-1:0]) + (64'd1 << (rsh - 6'd1))) >> rsh;
         end
      end else if (s_val < 12'sd0) begin
         if (s_neg >= $signed(12'(LSHIFT_LIMIT))) begin
            shifted = 64'(lim_now);
         end else if (64'(cur_abs[MANT_W-1:0]) > (64'(lim_now) >> lsh)) begin
            shifted = 64'(lim_now);
         end else begin
            shifted = 64'(cur_abs[MANT_W-1:0]) << lsh;
         end
      end
      lim_out  = neg_ff ? (SAT_W'(1) << OUT_FRAC_BITS)
                        : (SAT_W'(1) << OUT_FRAC_BITS) - SAT_W'(1);
      mag_sat  = (mag_ff > lim_out) ? lim_out : mag_ff;
      amp_full = neg_ff ? -mag_sat : mag_sat;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      amp_in        = amp_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      x_in          = x_ff;
      t_in          = t_ff;
      e_in          = e_ff;
      f_in          = f_ff;
      j_in          = j_ff;
      m_in          = m_ff;
      c_in          = c_ff;
      bterm_in      = bterm_ff;
      aterm_in      = aterm_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               x_in = req_position;
               if (32'(req_order) > MAX_ORDER) begin
                  n_in = K_W'(MAX_ORDER);
               end else begin
                  n_in = K_W'(req_order);
               end
               state_in = S_SQ;
            end
         end
         S_SQ: state_in = S_T;
         S_T: begin
            t_in     = tsum[46:15];
            state_in = S_U;
         end
         S_U: state_in = S_EF;
         S_EF: begin
            e_in     = EXP_W'(prod_ff[62:54]);
            f_in     = prod_ff[53:24];
            m_in     = M_W'(1) << 31;
            j_in     = J_W'(1);
            state_in = S_EXP;
         end
         S_EXP: begin
            if (f_ff[EXP_FRAC_BITS-1]) begin
               state_in = S_EXPW;
            end else begin
               f_in     = f_ff << 1;
               j_in     = j_ff + J_W'(1);
               state_in = exp_last ? S_P0 : S_EXP;
            end
         end
         S_EXPW: begin
            m_in     = msum[62:31];
            f_in     = f_ff << 1;
            j_in     = j_ff + J_W'(1);
            state_in = exp_last ? S_P0 : S_EXP;
         end
         S_P0: state_in = S_P0W;
         S_P0W: begin
            cur_in   = ACC_W'(msum[62:31]);
            prev_in  = '0;
            k_in     = K_W'(1);
            state_in = (n_ff == '0) ? S_OUT1 : S_CA;
         end
         S_CA: state_in = S_C;
         S_C: begin
            c_in     = rs24[C_W-1:0];
            state_in = S_M1;
         end
         S_M1: begin
            bterm_in = rs30[MANT_W-1:0];
            state_in = S_M1W;
         end
         S_M1W: begin
            aterm_in = rs25[ACC_W-1:0];
            state_in = S_SUB;
         end
         S_SUB: begin
            cur_in   = aterm_ff - ACC_W'(bterm_ff);
            prev_in  = cur_ff[MANT_W-1:0];
            state_in = S_NORM;
         end
         S_NORM: begin
            if (mant_big) begin
               cur_in  = cur_half[ACC_W-1:0];
               prev_in = prev_half[MANT_W-1:0];
               e_in    = e_ff - EXP_W'(1);
            end else if (k_ff == n_ff) begin
               state_in = S_OUT1;
            end else begin
               k_in     = k_ff + K_W'(1);
               state_in = S_CA;
            end
         end
         S_OUT1: begin
            mag_in   = SAT_W'(shifted);
            neg_in   = cur_ff[ACC_W-1];
            state_in = S_OUT2;
         end
         S_OUT2: begin
            // wait for the output register to drain
            if (!rsp_tvalid_ff || rsp_tready) begin
               amp_in        = amp_full[AMP_W-1:0];
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      amp_ff   <= amp_in;
      n_ff     <= n_in;
      k_ff     <= k_in;
      x_ff     <= x_in;
      t_ff     <= t_in;
      e_ff     <= e_in;
      f_ff     <= f_in;
      j_ff     <= j_in;
      m_ff     <= m_in;
      c_ff     <= c_in;
      bterm_ff <= bterm_in;
      aterm_ff <= aterm_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
   end

endmodule

[src/hfe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfe_checker
// Port-level checks on the Hermite function evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module hfe_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [hfe_pkg::REQ_DATA_W-1:0] req_tdata,  // order[4:0], position[28:5]
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [hfe_pkg::RSP_DATA_W-1:0] rsp_tdata   // amplitude[30:0]
);
   import hfe_pkg::*;

   // one word in flight: taking a word closes the input side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input still ready right after a word was taken");

   // a waiting input word is held until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=> (req_tvalid && $stable(req_tdata)))
      else $error("input word changed or dropped while waiting");

   // a result shows up only as the sequencer returns to idle
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result appeared while the input side was busy");

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

endmodule

bind hermite_function_evaluator hfe_checker u_hfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
